// File: sv/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

  // Field and datapath widths
  localparam int PIX_W    = 8;
  localparam int OD_W     = 16;
  localparam int COEF_W   = 18;
  localparam int REG_W    = 3 * COEF_W;
  localparam int PROD_W   = COEF_W + OD_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int THR_W    = 28;
  localparam int LEVELS   = 256;
  localparam int THR_N    = LEVELS - 1;
  localparam int CFG_IDX_W = 2;
  localparam int STAIN_MAX = 3;
  localparam int STAIN_COUNT_DEF = 3;

  // ln(2) in unsigned Q.32
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  // ln(2^-52) offset used for a zero channel
  localparam logic [63:0] EPS_EXP = 64'd52;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_RED   = 2'd0,
    REG_INV_GREEN = 2'd1,
    REG_INV_BLUE  = 2'd2
  } reg_idx_t;

  // Stage advance strobes of the pipeline
  typedef struct packed {
    logic pix;
    logic od;
    logic prod;
    logic sum;
    logic therm;
    logic out;
  } adv_t;

  typedef logic [STAIN_MAX-1:0][OD_W-1:0]  od_vec_t;
  typedef logic [LEVELS-1:0][OD_W-1:0]     od_table_t;
  typedef logic [THR_N-1:0][THR_W-1:0]     thr_table_t;

  // Restoring divide, evaluated at elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Natural log of n (1..1023) in unsigned Q.32, atanh series
  function automatic logic [63:0] ln_q32(input logic [9:0] n);
    logic [63:0] k;
    logic [63:0] base;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] acc;
    k = '0;
    if (n == '0) begin
      return '0;
    end
    for (int i = 1; i <= 9; i++) begin
      if ((n >> i) != '0) begin
        k = 64'(i);
      end
    end
    base = 64'd1 << k;
    z    = udiv(({54'd0, n} - base) << 32, {54'd0, n} + base);
    z2   = (z * z) >> 32;
    acc  = z;
    p    = z;
    for (int j = 3; j <= 41; j += 2) begin
      p   = (p * z2) >> 32;
      acc = acc + udiv(p, 64'(j));
    end
    return k * LN2_Q32 + 2 * acc;
  endfunction

  // Optical density per channel value, unsigned Q6.10
  function automatic od_table_t build_od();
    od_table_t   t;
    logic [63:0] d;
    for (int x = 0; x < LEVELS; x++) begin
      if (x == 0) begin
        d = ln_q32(10'd255) + EPS_EXP * LN2_Q32;
      end else begin
        d = ln_q32(10'd255) - ln_q32(10'(x));
      end
      d = (d + (64'd1 << 21)) >> 22;
      if (d > 64'hFFFF) begin
        d = 64'hFFFF;
      end
      t[x] = d[OD_W-1:0];
    end
    return t;
  endfunction

  // Intensity thresholds ln(510/(2k+1)) in Q.24 (floor of the Q.32 value)
  function automatic thr_table_t build_thr();
    thr_table_t  t;
    logic [63:0] d;
    for (int k = 0; k < THR_N; k++) begin
      d    = (ln_q32(10'd510) - ln_q32(10'(2 * k + 1))) >> 8;
      t[k] = d[THR_W-1:0];
    end
    return t;
  endfunction

  localparam od_table_t  OD_TABLE  = build_od();
  localparam thr_table_t THR_TABLE = build_thr();

endpackage

// File: sv/scd_density.sv
`timescale 1ns / 1ps

module scd_density (
  input  logic                          clk,
  input  scd_pkg::adv_t                 adv,
  input  logic [scd_pkg::PIX_W-1:0]     in_red,
  input  logic [scd_pkg::PIX_W-1:0]     in_green,
  input  logic [scd_pkg::PIX_W-1:0]     in_blue,
  output scd_pkg::od_vec_t              od
);

  logic [scd_pkg::PIX_W-1:0] red_r;
  logic [scd_pkg::PIX_W-1:0] green_r;
  logic [scd_pkg::PIX_W-1:0] blue_r;
  scd_pkg::od_vec_t          od_r;
  scd_pkg::od_vec_t          od_nxt;

  // Capture the pixel request
  always_ff @(posedge clk) begin
    if (adv.pix) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
  end

  // Look up the optical density of each channel
  always_comb begin
    od_nxt[0] = scd_pkg::OD_TABLE[red_r];
    od_nxt[1] = scd_pkg::OD_TABLE[green_r];
    od_nxt[2] = scd_pkg::OD_TABLE[blue_r];
  end

  always_ff @(posedge clk) begin
    if (adv.od) begin
      od_r <= od_nxt;
    end
  end

  assign od = od_r;

endmodule

// File: sv/scd_mix.sv
`timescale 1ns / 1ps

module scd_mix (
  input  logic                               clk,
  input  scd_pkg::adv_t                      adv,
  input  logic [scd_pkg::REG_W-1:0]          row,
  input  scd_pkg::od_vec_t                   od,
  output logic signed [scd_pkg::SUM_W-1:0]   sum
);

  logic signed [scd_pkg::PROD_W-1:0] prod_nxt [3];
  logic signed [scd_pkg::PROD_W-1:0] prod_r   [3];
  logic signed [scd_pkg::SUM_W-1:0]  sum_nxt;
  logic signed [scd_pkg::SUM_W-1:0]  sum_r;

  // Multiply each density by its signed Q4.14 coefficient
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod_nxt[ch] =
        scd_pkg::PROD_W'($signed(row[ch*scd_pkg::COEF_W +: scd_pkg::COEF_W])) *
        scd_pkg::PROD_W'($signed({1'b0, od[ch]}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_r[ch] <= prod_nxt[ch];
      end
    end
  end

  // Add the three products into the stain density
  assign sum_nxt = scd_pkg::SUM_W'(prod_r[0]) + scd_pkg::SUM_W'(prod_r[1]) +
                   scd_pkg::SUM_W'(prod_r[2]);

  always_ff @(posedge clk) begin
    if (adv.sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// File: sv/scd_intensity.sv
`timescale 1ns / 1ps

module scd_intensity (
  input  logic                              clk,
  input  scd_pkg::adv_t                     adv,
  input  logic signed [scd_pkg::SUM_W-1:0]  sum,
  output logic [scd_pkg::PIX_W-1:0]         stain
);

  logic [scd_pkg::THR_N-1:0] therm_nxt;
  logic [scd_pkg::THR_N-1:0] therm_r;
  logic [scd_pkg::PIX_W-1:0] level;
  logic [scd_pkg::PIX_W-1:0] probe;
  logic [scd_pkg::PIX_W-1:0] stain_r;

  // Compare the density against every level threshold; the hits form a prefix
  always_comb begin
    for (int k = 0; k < scd_pkg::THR_N; k++) begin
      therm_nxt[k] = sum <= $signed(scd_pkg::SUM_W'(scd_pkg::THR_TABLE[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv.therm) begin
      therm_r <= therm_nxt;
    end
  end

  // Convert the thermometer code to a count by binary search
  always_comb begin
    level = '0;
    probe = '0;
    for (int b = scd_pkg::PIX_W - 1; b >= 0; b--) begin
      probe = level | scd_pkg::PIX_W'((1 << b) - 1);
      if (therm_r[probe]) begin
        level = level | scd_pkg::PIX_W'(1 << b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.out) begin
      stain_r <= level;
    end
  end

  assign stain = stain_r;

endmodule

// File: sv/stain_color_deconvolution.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// in_      | input     | in_valid/in_ready  | in_red, in_green, in_blue (8 b each)
// out_     | output    | out_valid/out_ready| out_stain_one/_two/_three (8 b each)
// cfg_     | input     | cfg_we             | cfg_index (2 b), cfg_data (54 b)
//
// One pixel per cycle while out_ready holds; a result passes through six
// register stages (pixel, density, products, sum, threshold compare, output).
// Each stage moves on when it is empty or the stage after it moves, so
// bubbles close up under an output stall and input is refused only when full.
// Synchronous active-low reset empties the pipeline and zeroes the matrix rows.

module stain_color_deconvolution #(
  parameter int STAIN_COUNT = scd_pkg::STAIN_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [scd_pkg::PIX_W-1:0]         in_red,
  input  logic [scd_pkg::PIX_W-1:0]         in_green,
  input  logic [scd_pkg::PIX_W-1:0]         in_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scd_pkg::PIX_W-1:0]         out_stain_one,
  output logic [scd_pkg::PIX_W-1:0]         out_stain_two,
  output logic [scd_pkg::PIX_W-1:0]         out_stain_three,
  input  logic                              cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scd_pkg::REG_W-1:0]         cfg_data
);

  logic [scd_pkg::REG_W-1:0] row_r [scd_pkg::STAIN_MAX];
  scd_pkg::adv_t             adv;
  scd_pkg::adv_t             vld_r;
  scd_pkg::adv_t             vld_nxt;
  scd_pkg::od_vec_t          od;
  logic [scd_pkg::PIX_W-1:0] stain [scd_pkg::STAIN_MAX];

  // Hold the inverse matrix rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < scd_pkg::STAIN_MAX; s++) begin
        row_r[s] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        scd_pkg::REG_INV_RED:   row_r[0] <= cfg_data;
        scd_pkg::REG_INV_GREEN: row_r[1] <= cfg_data;
        scd_pkg::REG_INV_BLUE:  row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv.out   = !vld_r.out   || out_ready;
    adv.therm = !vld_r.therm || adv.out;
    adv.sum   = !vld_r.sum   || adv.therm;
    adv.prod  = !vld_r.prod  || adv.sum;
    adv.od    = !vld_r.od    || adv.prod;
    adv.pix   = !vld_r.pix   || adv.od;

    vld_nxt.pix   = adv.pix   ? in_valid    : vld_r.pix;
    vld_nxt.od    = adv.od    ? vld_r.pix   : vld_r.od;
    vld_nxt.prod  = adv.prod  ? vld_r.od    : vld_r.prod;
    vld_nxt.sum   = adv.sum   ? vld_r.prod  : vld_r.sum;
    vld_nxt.therm = adv.therm ? vld_r.sum   : vld_r.therm;
    vld_nxt.out   = adv.out   ? vld_r.therm : vld_r.out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv.pix;
  assign out_valid = vld_r.out;

  scd_density u_density (
    .clk      (clk),
    .adv      (adv),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .od       (od)
  );

  // One lane per configured stain; the rest read zero
  for (genvar s = 0; s < scd_pkg::STAIN_MAX; s++) begin : g_lane
    if (s < STAIN_COUNT) begin : g_on
      logic signed [scd_pkg::SUM_W-1:0] sum;

      scd_mix u_mix (
        .clk (clk),
        .adv (adv),
        .row (row_r[s]),
        .od  (od),
        .sum (sum)
      );

      scd_intensity u_intensity (
        .clk   (clk),
        .adv   (adv),
        .sum   (sum),
        .stain (stain[s])
      );
    end else begin : g_off
      assign stain[s] = '0;
    end
  end

  assign out_stain_one   = stain[0];
  assign out_stain_two   = stain[1];
  assign out_stain_three = stain[2];

endmodule

// File: tb/stain_color_deconvolution_test.sv
`timescale 1ns / 1ps

// ln(2) in unsigned Q.32 and the power of two behind the zero-channel epsilon
localparam bit [63:0] LN2_FRAC32        = 64'd2977044472;
localparam bit [63:0] ZERO_CHANNEL_LOG2 = 64'd52;
localparam int        MAX_REPORTED      = 10;

typedef struct packed {
  logic [7:0] stain_one;
  logic [7:0] stain_two;
  logic [7:0] stain_three;
} stain_triplet_t;

class stain_scoreboard;
  bit [53:0]      inv_row [3];
  bit [15:0]      od_lut [256];
  bit [63:0]      thr_lut [255];
  stain_triplet_t expected_stains [$];
  int             mismatches;

  function new();
    for (int x = 0; x < 256; x++) od_lut[x] = channel_density(8'(x));
    // thresholds ln(510 / (2k + 1)) in Q.32, decreasing with k
    for (int k = 0; k < 255; k++) thr_lut[k] = log_q32(10'd510) - log_q32(10'(2 * k + 1));
    foreach (inv_row[i]) inv_row[i] = '0;
    mismatches = 0;
  endfunction

  // Natural log of n in Q.32: octave count plus an atanh series on the mantissa
  function bit [63:0] log_q32(input bit [9:0] n);
    bit [63:0] k;
    bit [63:0] base;
    bit [63:0] z;
    bit [63:0] z2;
    bit [63:0] p;
    bit [63:0] acc;
    if (n == '0) return '0;
    k = '0;
    while (k < 9 && (n >> (k + 1)) != '0) k++;
    base = 64'd1 << k;
    z    = ((64'(n) - base) << 32) / (64'(n) + base);
    z2   = (z * z) >> 32;
    acc  = z;
    p    = z;
    for (int j = 3; j <= 41; j += 2) begin
      p   = (p * z2) >> 32;
      acc = acc + p / 64'(j);
    end
    return k * LN2_FRAC32 + 2 * acc;
  endfunction

  // Optical density of one channel, unsigned Q6.10, rounded and clamped
  function bit [15:0] channel_density(input bit [7:0] x);
    bit [63:0] d;
    if (x == '0) begin
      d = log_q32(10'd255) + ZERO_CHANNEL_LOG2 * LN2_FRAC32;
    end else begin
      d = log_q32(10'd255) - log_q32(10'(x));
    end
    d = (d + (64'd1 << 21)) >> 22;
    if (d > 64'hFFFF) d = 64'hFFFF;
    return d[15:0];
  endfunction

  // Intensity from a Q.24 stain density: count of thresholds not below it
  function bit [7:0] to_intensity(input longint c);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint      c32;
    if (c <= 0) return 8'd255;
    c32 = c * 256;
    lo  = 0;
    hi  = 255;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (c32 <= longint'(thr_lut[mid])) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo[7:0];
  endfunction

  function stain_triplet_t predict_stains(input bit [7:0] r, input bit [7:0] g,
                                          input bit [7:0] b);
    longint            od [3];
    longint            c;
    logic signed [17:0] cf;
    bit [7:0]          lvl [3];
    od[0] = longint'(od_lut[r]);
    od[1] = longint'(od_lut[g]);
    od[2] = longint'(od_lut[b]);
    for (int s = 0; s < 3; s++) begin
      if (s >= scd_pkg::STAIN_COUNT_DEF) begin
        lvl[s] = '0;
      end else begin
        c = 0;
        for (int ch = 0; ch < 3; ch++) begin
          cf = inv_row[s][18 * ch +: 18];
          c  = c + longint'(cf) * od[ch];
        end
        lvl[s] = to_intensity(c);
      end
    end
    return '{lvl[0], lvl[1], lvl[2]};
  endfunction

  // Mirror a register write; indexes past the list are ignored
  function void set_row(input bit [1:0] idx, input bit [53:0] data);
    if (idx == scd_pkg::REG_INV_RED) begin
      inv_row[0] = data;
    end else if (idx == scd_pkg::REG_INV_GREEN) begin
      inv_row[1] = data;
    end else if (idx == scd_pkg::REG_INV_BLUE) begin
      inv_row[2] = data;
    end
  endfunction

  function void note_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
    expected_stains = {expected_stains, predict_stains(r, g, b)};
  endfunction

  function void check_stains(input stain_triplet_t got);
    stain_triplet_t want;
    if (expected_stains.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("unexpected result %0d %0d %0d", got.stain_one, got.stain_two,
                 got.stain_three);
      return;
    end
    want = expected_stains.pop_front();
    if (got.stain_one !== want.stain_one || got.stain_two !== want.stain_two ||
        got.stain_three !== want.stain_three) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("stain mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                 want.stain_one, want.stain_two, want.stain_three,
                 got.stain_one, got.stain_two, got.stain_three);
    end
  endfunction

  function int pending();
    return expected_stains.size();
  endfunction
endclass

module stain_color_deconvolution_test;
  localparam int LATENCY      = 5;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_OFF     = 80;
  localparam int IDLE_PERCENT = 6;
  localparam int COEF_MAX     = 131071;
  localparam int COEF_MIN     = -131072;
  localparam logic [scd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [scd_pkg::PIX_W-1:0]     in_red;
  logic [scd_pkg::PIX_W-1:0]     in_green;
  logic [scd_pkg::PIX_W-1:0]     in_blue;
  logic                          out_valid;
  logic                          out_ready;
  logic [scd_pkg::PIX_W-1:0]     out_stain_one;
  logic [scd_pkg::PIX_W-1:0]     out_stain_two;
  logic [scd_pkg::PIX_W-1:0]     out_stain_three;
  logic                          cfg_we;
  logic [scd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [scd_pkg::REG_W-1:0]     cfg_data;

  stain_scoreboard stain_sb;
  bit              tx_idle_on = 1'b1;
  bit              rx_idle_on = 1'b1;
  int              rx_hold_left = 0;
  int              quiet_cycles = 0;

  stain_color_deconvolution uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stain_one   (out_stain_one),
    .out_stain_two   (out_stain_two),
    .out_stain_three (out_stain_three),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random back-pressure, or a counted hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(rx_idle_on && $urandom_range(99, 0) < IDLE_PERCENT);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      stain_sb.check_stains('{out_stain_one, out_stain_two, out_stain_three});
  end

  // Abort when no request moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [scd_pkg::REG_W-1:0] pack_row(input int red_cf, input int green_cf,
                                                         input int blue_cf);
    return {18'(blue_cf), 18'(green_cf), 18'(red_cf)};
  endfunction

  function automatic int rand_coef();
    case ($urandom_range(3, 0))
      0:       return int'($urandom_range(262143, 0));
      1:       return int'($urandom_range(32768, 0)) - 16384;
      2:       return int'($urandom_range(4096, 0));
      default: return int'($urandom_range(80000, 0)) - 40000;
    endcase
  endfunction

  function automatic logic [7:0] rand_level();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) begin
      case ($urandom_range(3, 0))
        0:       return 8'd0;
        1:       return 8'd1;
        2:       return 8'd254;
        default: return 8'd255;
      endcase
    end else if (pick <= 3) begin
      return 8'($urandom_range(255, 150));
    end
    return 8'($urandom_range(255, 0));
  endfunction

  // Offer one pixel request and hold it until taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (tx_idle_on && $urandom_range(99, 0) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    stain_sb.note_pixel(r, g, b);
  endtask

  task automatic write_reg(input logic [scd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scd_pkg::REG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    stain_sb.set_row(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input logic [scd_pkg::REG_W-1:0] row_one,
                             input logic [scd_pkg::REG_W-1:0] row_two,
                             input logic [scd_pkg::REG_W-1:0] row_three);
    write_reg(scd_pkg::REG_INV_RED, row_one);
    write_reg(scd_pkg::REG_INV_GREEN, row_two);
    write_reg(scd_pkg::REG_INV_BLUE, row_three);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stain_sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic random_pixels(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    stain_sb  = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero matrix after reset: every stain density is zero, so full intensity
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd128, 8'd255);
    settle();

    // Typical three-stain inverse, plus a write past the register list
    load_matrix(pack_row(30769, -1082, -9830), pack_row(-16712, 18497, -7905),
                pack_row(-9000, -2130, 25722));
    write_reg(REG_UNUSED, scd_pkg::REG_W'({$urandom(), $urandom()}));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd200, 8'd150, 8'd180);
    send_pixel(8'd128, 8'd64, 8'd32);
    settle();

    // Largest positive coefficients: dark pixels floor at zero
    load_matrix(pack_row(COEF_MAX, COEF_MAX, COEF_MAX), pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd254, 8'd255, 8'd255);
    settle();

    // Most negative coefficients: densities go negative and saturate
    load_matrix(pack_row(COEF_MIN, COEF_MIN, COEF_MIN), pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd1);
    settle();

    // Mixed extremes and the smallest positive coefficient
    load_matrix(pack_row(COEF_MAX, COEF_MIN, 0), pack_row(1, 0, 0), pack_row(0, 0, COEF_MIN));
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd254, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd255);
    settle();

    // Random matrices with random pixels
    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(pack_row(rand_coef(), rand_coef(), rand_coef()),
                  pack_row(rand_coef(), rand_coef(), rand_coef()),
                  pack_row(rand_coef(), rand_coef(), rand_coef()));
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      random_pixels(20);
      // stall the result side long enough for the pipe to fill
      if (ph == 3) rx_hold_left = HOLD_OFF;
      // hold the sender until every result is back
      if (ph == 5) settle();
      random_pixels(60);
      settle();
    end

    if (stain_sb.mismatches == 0 && stain_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/scd_pkg.sv
sv/scd_density.sv
sv/scd_mix.sv
sv/scd_intensity.sv
sv/stain_color_deconvolution.sv
tb/stain_color_deconvolution_test.sv
